### sv/aes_enc_pkg.sv
// aes_enc_pkg: constants, s-box table and round functions for aes block encryption
// used by aes_block_encrypt_core; depends on nothing
package aes_enc_pkg;

  localparam int unsigned BlockW   = 128;
  localparam int unsigned WordW    = 32;
  localparam int unsigned KeyRegW  = 64;
  localparam int unsigned NumRk    = 60;
  localparam int unsigned MaxRnd   = 14;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] CfgKeyLen = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgKey0   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgKey1   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgKey2   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgKey3   = 3'd4;

  localparam logic [7:0] RconInit = 8'h01;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [WordW-1:0] sub_word(input logic [WordW-1:0] w);
    sub_word = {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
  endfunction

  // byte i of the state sits at [127-8i -: 8]
  function automatic logic [BlockW-1:0] sub_shift(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = Sbox[s[127-8*(r+4*((c+r)%4)) -: 8]];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [BlockW-1:0] mix_columns(input logic [BlockW-1:0] s);
    logic [BlockW-1:0] t;
    logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      d0 = xtime(a0);
      d1 = xtime(a1);
      d2 = xtime(a2);
      d3 = xtime(a3);
      t[127-32*c -: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
      t[119-32*c -: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
      t[111-32*c -: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
      t[103-32*c -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
    end
    mix_columns = t;
  endfunction

endpackage

### sv/aes_block_encrypt_core.sv
// aes_block_encrypt_core: pipelined aes-128/192/256 encryption with key expansion sequencer
// depends on aes_enc_pkg
//
// usage:
//   s_axis: one 128-bit plaintext item per accepted beat; tdata[63:0] holds
//   plaintext_high, tdata[127:64] plaintext_low (byte 0 most significant).
//   m_axis: one ciphertext item per plaintext item, in order, same packing.
//   cfg: index/data write channel, always ready; index 0 key length, 1..4 key
//   words. write only while no item is in flight.
// throughput: one item per cycle when not held by back-pressure or key expansion; each
//   accepted item passes through an initial key-add stage and fourteen round stages to
//   m_axis_tvalid_o; for shorter keys the rounds past the last one pass the state through.
// key expansion: after reset and after every config write, a sequencer derives
//   one round-key word per cycle; s_axis_tready_o is low meanwhile.
// stall: each stage has its own valid bit and loads when the stage after it
//   is free, so bubbles close up and items keep entering while a result waits;
//   nothing is lost or repeated.
module aes_block_encrypt_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [aes_enc_pkg::BlockW-1:0]     s_axis_tdata_i,  // plaintext_high, plaintext_low
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [aes_enc_pkg::BlockW-1:0]     m_axis_tdata_o,  // ciphertext_high, ciphertext_low
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [aes_enc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [aes_enc_pkg::KeyRegW-1:0]    cfg_data_i
);
  import aes_enc_pkg::*;

  logic [1:0]          key_len_q;
  logic [KeyRegW-1:0]  key_q [4];
  logic                busy_q;
  logic [5:0]          idx_q;
  logic [2:0]          imod_q;
  logic [7:0]          rcon_q;
  logic [WordW-1:0]    win_q [8];
  logic [WordW-1:0]    rk_q [NumRk];
  logic [WordW-1:0]    new_w;
  logic [WordW-1:0]    far_w;
  logic [WordW-1:0]    key_w;
  logic [3:0]          nk;
  logic [3:0]          nr;
  logic                in_load;
  logic                cfg_wr;

  logic [BlockW-1:0]   st_q [MaxRnd+1];
  logic                v_q  [MaxRnd+1];
  logic                rdy  [MaxRnd+1];
  logic [BlockW-1:0]   st_d [MaxRnd+1];

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  always_comb begin
    priority if (key_len_q[1]) begin
      nk = 4'd8;
      far_w = win_q[0];
    end else if (key_len_q[0]) begin
      nk = 4'd6;
      far_w = win_q[2];
    end else begin
      nk = 4'd4;
      far_w = win_q[4];
    end
    nr = nk + 4'd6;
  end

  assign in_load = ({1'b0, idx_q} < {3'b000, nk});

  always_comb begin
    key_w = idx_q[0] ? key_q[idx_q[2:1]][31:0] : key_q[idx_q[2:1]][63:32];
    priority if (in_load) begin
      new_w = key_w;
    end else if (imod_q == 3'd0) begin
      new_w = far_w ^ sub_word({win_q[7][23:0], win_q[7][31:24]}) ^ {rcon_q, 24'h0};
    end else if (key_len_q[1] && imod_q == 3'd4) begin
      new_w = far_w ^ sub_word(win_q[7]);
    end else begin
      new_w = far_w ^ win_q[7];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= '0;
      for (int j = 0; j < 4; j++) key_q[j] <= '0;
      busy_q <= 1'b1;
      idx_q  <= '0;
      imod_q <= '0;
      rcon_q <= RconInit;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        CfgKeyLen: key_len_q <= cfg_data_i[1:0];
        CfgKey0:   key_q[0] <= cfg_data_i;
        CfgKey1:   key_q[1] <= cfg_data_i;
        CfgKey2:   key_q[2] <= cfg_data_i;
        CfgKey3:   key_q[3] <= cfg_data_i;
        default: ;
      endcase
      busy_q <= 1'b1;
      idx_q  <= '0;
      imod_q <= '0;
      rcon_q <= RconInit;
    end else if (busy_q) begin
      idx_q <= idx_q + 6'd1;
      if (idx_q == 6'(NumRk - 1)) busy_q <= 1'b0;
      if (!in_load) begin
        imod_q <= ({1'b0, imod_q} == nk - 4'd1) ? 3'd0 : imod_q + 3'd1;
        if (imod_q == 3'd0) rcon_q <= xtime(rcon_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !cfg_wr) begin
      for (int j = 0; j < 7; j++) win_q[j] <= win_q[j+1];
      win_q[7] <= new_w;
      rk_q[idx_q] <= new_w;
    end
  end

  // round pipeline
  always_comb begin
    st_d[0] = {s_axis_tdata_i[63:0], s_axis_tdata_i[127:64]} ^
              {rk_q[0], rk_q[1], rk_q[2], rk_q[3]};
    for (int r = 1; r <= MaxRnd; r++) begin
      if (r < nr) begin
        st_d[r] = mix_columns(sub_shift(st_q[r-1])) ^
                  {rk_q[4*r], rk_q[4*r+1], rk_q[4*r+2], rk_q[4*r+3]};
      end else if (r == nr) begin
        st_d[r] = sub_shift(st_q[r-1]) ^
                  {rk_q[4*r], rk_q[4*r+1], rk_q[4*r+2], rk_q[4*r+3]};
      end else begin
        st_d[r] = st_q[r-1];
      end
    end
  end

  always_comb begin
    rdy[MaxRnd] = !v_q[MaxRnd] || m_axis_tready_i;
    for (int r = MaxRnd - 1; r >= 0; r--) rdy[r] = !v_q[r] || rdy[r+1];
  end

  assign s_axis_tready_o = rdy[0] && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r <= MaxRnd; r++) v_q[r] <= 1'b0;
    end else begin
      if (rdy[0]) v_q[0] <= s_axis_tvalid_i && !busy_q;
      for (int r = 1; r <= MaxRnd; r++) begin
        if (rdy[r]) v_q[r] <= v_q[r-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && s_axis_tvalid_i && !busy_q) st_q[0] <= st_d[0];
    for (int r = 1; r <= MaxRnd; r++) begin
      if (rdy[r] && v_q[r-1]) st_q[r] <= st_d[r];
    end
  end

  assign m_axis_tvalid_o = v_q[MaxRnd];
  assign m_axis_tdata_o  = {st_q[MaxRnd][63:0], st_q[MaxRnd][127:64]};

endmodule
